>>> rtl/core/buddy_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// shared property forms for the checker of the allocator ports
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off while reset is high
`define BBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define BBA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define BBA_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// types, codes and helper functions of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_CHUNKS = 1024;
  localparam int ORDER_CAP  = 10;
  localparam int IDX_W      = $clog2(MAX_CHUNKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ORD_W      = 4;
  localparam int SZ_W       = 17;
  localparam int NLIST      = ORDER_CAP + 1;
  localparam int LSEL_W     = $clog2(NLIST);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ORD_W-1:0] ord_t;
  typedef logic [SZ_W-1:0]  sz_t;

  typedef struct packed {
    logic free;
    ord_t order;
  } tag_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_FREE    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_NOSPACE = 2'd3
  } status_t;

  localparam logic [PADDR_W-3:0] REG_POOL_SIZE = '0;

  typedef enum logic [4:0] {
    S_BUILD_INIT,
    S_BUILD_STEP,
    S_BUILD_CLR,
    S_IDLE,
    S_DECODE,
    S_AL_SCAN,
    S_AL_SPLIT,
    S_RS_WAIT,
    S_RS_SPLIT,
    S_FR_WAIT,
    S_FR_CLIMB,
    S_FR_BWAIT,
    S_PU_START,
    S_PU_WAIT,
    S_PU_LINK,
    S_UL_START,
    S_UL_WAIT,
    S_TAG,
    S_DONE
  } fsm_t;

  function automatic sz_t blk_size(input ord_t o);
    return sz_t'(1) << o;
  endfunction

  function automatic idx_t blk_mask(input ord_t o);
    return idx_t'(blk_size(o) - sz_t'(1));
  endfunction

  function automatic logic valid_blk(input idx_t i, input ord_t o,
                                     input ord_t top, input cnt_t cnt);
    return (o <= top) && ((i & blk_mask(o)) == '0) &&
           ((sz_t'(i) + blk_size(o)) <= sz_t'(cnt));
  endfunction

  // floor(log2 cnt), capped at the largest order
  function automatic ord_t top_of(input cnt_t cnt);
    ord_t lg;
    lg = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (cnt[b]) lg = ord_t'(b);
    end
    if (lg > ord_t'(ORDER_CAP)) lg = ord_t'(ORDER_CAP);
    return lg;
  endfunction

endpackage

>>> rtl/core/bba_if.sv
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// valid/ready channels for allocator requests and results
// ----------------------------------------------------------------------------
interface bba_req_if;
  import bba_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  idx_t block_index;
  ord_t block_order;
  modport source (output valid, opcode, block_index, block_order, input ready);
  modport sink   (input valid, opcode, block_index, block_order, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  idx_t granted_index;
  modport source (output valid, status, granted_index, input ready);
  modport sink   (input valid, status, granted_index, output ready);
endinterface

>>> rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// power-of-two block allocator with one fifo free list per order
// ----------------------------------------------------------------------------
// channel  dir  payload                              transfer when
// req      in   opcode, block_index, block_order     req.valid & req.ready
// rsp      out  status, granted_index                rsp.valid & rsp.ready
// apb      in   pool size at byte address 0          psel & penable & pwrite
//
// one request at a time: a small sequencer drives the tag and link memories;
// an item's time grows with each order scanned, split or climbed, each list
// push (shorter onto an empty list), each unlink (shorter for a lone block)
// and each chunk retagged (the tag memory write port sets the rate)
// after reset and after every legal pool size write the pool is rebuilt,
// req.ready low meanwhile
// the result register lets the next request in while a result waits
// ----------------------------------------------------------------------------
module buddy_block_allocator (
  input  logic                         clk,
  input  logic                         rst,
  bba_req_if.sink                      req,
  bba_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bba_pkg::PADDR_W-1:0]  paddr,
  input  logic [bba_pkg::PDATA_W-1:0]  pwdata,
  output logic [bba_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import bba_pkg::*;

  // control state
  fsm_t state, state_next, ret, ret_next;
  cnt_t count;
  idx_t t_cnt, t_cnt_next;
  logic rsp_valid_r;

  // datapath registers
  ord_t top, top_next, cur, cur_next, ord_r, ord_r_next, a_ord, a_ord_next;
  idx_t idx_r, idx_r_next, base, base_next, a_idx, a_idx_next;
  idx_t p_head, p_head_next, p_tail, p_tail_next, res_gr, res_gr_next;
  logic [1:0] op_r, op_r_next;
  status_t res_st, res_st_next;
  logic a_free, a_free_next;
  cnt_t off, off_next;
  logic [1:0] rsp_status_r;
  idx_t rsp_granted_r;

  // memories, one write and one registered read port each
  tag_t tag_mem [MAX_CHUNKS];
  idx_t prev_mem [MAX_CHUNKS];
  idx_t next_mem [MAX_CHUNKS];
  tag_t tag_q;
  idx_t prev_q, next_q;
  logic tag_we, prev_we, next_we;
  idx_t tag_waddr, tag_raddr, prev_waddr, prev_raddr, next_waddr, next_raddr;
  idx_t prev_wdata, next_wdata;
  tag_t tag_wdata;

  // per-order list heads and lengths
  idx_t list_head [NLIST];
  cnt_t list_len  [NLIST];
  logic list_clr, lh_we, ll_inc, ll_dec;
  idx_t lh_data;
  logic [LSEL_W-1:0] lsel;
  idx_t l_head;
  cnt_t l_len;

  // apb decode: only a legal pool size rebuilds
  logic cfg_wr, cfg_rebuild;
  cnt_t cfg_val;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_val     = pwdata[CNT_W-1:0];
  assign cfg_rebuild = cfg_wr && (paddr[PADDR_W-1:2] == REG_POOL_SIZE) &&
                       (cfg_val != '0) && (cfg_val <= cnt_t'(MAX_CHUNKS));
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_POOL_SIZE) ?
                  PDATA_W'(count) : '0;

  // handshakes
  logic req_take, out_free;
  assign req.ready = (state == S_IDLE);
  assign req_take  = req.valid && req.ready;
  assign out_free  = !rsp_valid_r || rsp.ready;
  assign rsp.valid = rsp_valid_r;
  assign rsp.status = rsp_status_r;
  assign rsp.granted_index = rsp_granted_r;

  // shared list read port
  assign lsel   = (state == S_AL_SCAN) ? LSEL_W'(cur) : LSEL_W'(a_ord);
  assign l_head = list_head[lsel];
  assign l_len  = list_len[lsel];

  // decision terms shared by the next-state and datapath blocks
  logic build_fits, rs_valid, rs_fit, fr_valid, bud_in, merge_ok, scan_fail;
  logic t_last;
  idx_t parent, bud, half, al_half;
  assign build_fits = (sz_t'(off) + blk_size(cur)) <= sz_t'(count);
  assign rs_valid   = valid_blk(idx_r, ord_r, top, count);
  assign rs_fit     = tag_q.free && (tag_q.order >= ord_r);
  assign fr_valid   = !tag_q.free && valid_blk(idx_r, tag_q.order, top, count);
  assign parent     = idx_r & ~blk_mask(cur + ord_t'(1));
  assign bud        = (idx_r == parent) ? parent + idx_t'(blk_size(cur)) : parent;
  assign bud_in     = cnt_t'(bud) < count;
  assign merge_ok   = (tag_q.order == cur) && tag_q.free;
  assign scan_fail  = (ord_r > top) || (cur > top);
  assign half       = base + idx_t'(blk_size(cur - ord_t'(1)));
  assign al_half    = half;
  assign t_last     = (t_cnt == blk_mask(a_ord));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_BUILD_INIT: state_next = S_BUILD_STEP;
      S_BUILD_STEP: begin
        if (build_fits) state_next = S_PU_START;
        else if (cur == '0) state_next = S_BUILD_CLR;
      end
      S_BUILD_CLR: if (off[IDX_W]) state_next = S_IDLE;
      S_IDLE:      if (req_take) state_next = S_DECODE;
      S_DECODE: begin
        case (op_r)
          OP_ALLOC:   state_next = S_AL_SCAN;
          OP_RESERVE: state_next = rs_valid ? S_RS_WAIT : S_DONE;
          OP_FREE:    state_next = (cnt_t'(idx_r) < count) ? S_FR_WAIT : S_DONE;
          default:    state_next = S_DONE;
        endcase
      end
      S_AL_SCAN: begin
        if (scan_fail) state_next = S_DONE;
        else if (l_len != '0) state_next = S_UL_START;
      end
      S_AL_SPLIT:  state_next = (cur > ord_r) ? S_PU_START : S_TAG;
      S_RS_WAIT:   state_next = rs_fit ? S_UL_START : S_DONE;
      S_RS_SPLIT:  state_next = (cur > ord_r) ? S_PU_START : S_TAG;
      S_FR_WAIT:   state_next = fr_valid ? S_FR_CLIMB : S_DONE;
      S_FR_CLIMB:  state_next = ((cur < top) && bud_in) ? S_FR_BWAIT : S_PU_START;
      S_FR_BWAIT:  state_next = merge_ok ? S_UL_START : S_PU_START;
      S_PU_START:  state_next = (l_len != '0) ? S_PU_WAIT : S_TAG;
      S_PU_WAIT:   state_next = S_PU_LINK;
      S_PU_LINK:   state_next = S_TAG;
      S_UL_START:  state_next = (l_len > cnt_t'(1)) ? S_UL_WAIT : ret;
      S_UL_WAIT:   state_next = ret;
      S_TAG:       if (t_last) state_next = ret;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_BUILD_INIT;
    endcase
    if (cfg_rebuild) state_next = S_BUILD_INIT;
  end

  // datapath and memory controls
  always_comb begin
    ret_next = ret;     t_cnt_next = t_cnt;   top_next = top;
    cur_next = cur;     ord_r_next = ord_r;   a_ord_next = a_ord;
    idx_r_next = idx_r; base_next = base;     a_idx_next = a_idx;
    p_head_next = p_head; p_tail_next = p_tail;
    res_gr_next = res_gr; res_st_next = res_st;
    op_r_next = op_r;   a_free_next = a_free; off_next = off;
    tag_we = 1'b0;  tag_waddr = a_idx;  tag_wdata = '{free: a_free, order: a_ord};
    tag_raddr = idx_r;
    prev_we = 1'b0; prev_waddr = a_idx; prev_wdata = a_idx; prev_raddr = a_idx;
    next_we = 1'b0; next_waddr = a_idx; next_wdata = a_idx; next_raddr = a_idx;
    list_clr = 1'b0; lh_we = 1'b0; lh_data = a_idx; ll_inc = 1'b0; ll_dec = 1'b0;
    case (state)
      S_BUILD_INIT: begin
        list_clr = 1'b1;
        top_next = top_of(count);
        cur_next = top_of(count);
        off_next = '0;
      end
      S_BUILD_STEP: begin
        if (build_fits) begin
          // largest aligned blocks first, each pushed free
          a_ord_next  = cur;
          a_idx_next  = off[IDX_W-1:0];
          a_free_next = 1'b1;
          off_next    = off + cnt_t'(blk_size(cur));
          ret_next    = S_BUILD_STEP;
        end else if (cur != '0) begin
          cur_next = cur - ord_t'(1);
        end
      end
      S_BUILD_CLR: begin
        // chunks past the pool end read as allocated order zero
        if (!off[IDX_W]) begin
          tag_we    = 1'b1;
          tag_waddr = off[IDX_W-1:0];
          tag_wdata = '0;
          off_next  = off + cnt_t'(1);
        end
      end
      S_IDLE: begin
        op_r_next   = req.opcode;
        idx_r_next  = req.block_index;
        ord_r_next  = req.block_order;
        res_gr_next = '0;
        res_st_next = ST_INVALID;
      end
      S_DECODE: begin
        cur_next = ord_r;
        if (op_r == OP_ALLOC) res_st_next = ST_NOSPACE;
      end
      S_AL_SCAN: begin
        if (!scan_fail) begin
          if (l_len == '0) begin
            cur_next = cur + ord_t'(1);
          end else begin
            base_next  = l_head;
            a_ord_next = cur;
            a_idx_next = l_head;
            ret_next   = S_AL_SPLIT;
          end
        end
      end
      S_AL_SPLIT: begin
        if (cur > ord_r) begin
          // right half goes back on the list one order down
          cur_next    = cur - ord_t'(1);
          a_ord_next  = cur - ord_t'(1);
          a_idx_next  = al_half;
          a_free_next = 1'b1;
          ret_next    = S_AL_SPLIT;
        end else begin
          a_ord_next  = ord_r;
          a_idx_next  = base;
          a_free_next = 1'b0;
          res_st_next = ST_OK;
          res_gr_next = base;
          ret_next    = S_DONE;
        end
      end
      S_RS_WAIT: begin
        if (!rs_fit) begin
          res_st_next = ST_BUSY;
        end else begin
          cur_next   = tag_q.order;
          base_next  = idx_r & ~blk_mask(tag_q.order);
          a_ord_next = tag_q.order;
          a_idx_next = idx_r & ~blk_mask(tag_q.order);
          ret_next   = S_RS_SPLIT;
        end
      end
      S_RS_SPLIT: begin
        if (cur > ord_r) begin
          // keep the half holding the target, free the other
          cur_next    = cur - ord_t'(1);
          a_ord_next  = cur - ord_t'(1);
          a_free_next = 1'b1;
          ret_next    = S_RS_SPLIT;
          if (idx_r < half) begin
            a_idx_next = half;
          end else begin
            a_idx_next = base;
            base_next  = half;
          end
        end else begin
          a_ord_next  = ord_r;
          a_idx_next  = idx_r;
          a_free_next = 1'b0;
          res_st_next = ST_OK;
          ret_next    = S_DONE;
        end
      end
      S_FR_WAIT: begin
        cur_next = tag_q.order;
      end
      S_FR_CLIMB: begin
        if ((cur < top) && bud_in) begin
          base_next = bud;
          tag_raddr = bud;
        end else begin
          a_ord_next  = cur;
          a_idx_next  = idx_r;
          a_free_next = 1'b1;
          res_st_next = ST_OK;
          ret_next    = S_DONE;
        end
      end
      S_FR_BWAIT: begin
        if (merge_ok) begin
          // buddy leaves its list, climb one order
          a_ord_next = cur;
          a_idx_next = base;
          idx_r_next = parent;
          cur_next   = cur + ord_t'(1);
          ret_next   = S_FR_CLIMB;
        end else begin
          a_ord_next  = cur;
          a_idx_next  = idx_r;
          a_free_next = 1'b1;
          res_st_next = ST_OK;
          ret_next    = S_DONE;
        end
      end
      S_PU_START: begin
        if (l_len != '0) begin
          p_head_next = l_head;
          prev_raddr  = l_head;
        end else begin
          prev_we = 1'b1;
          next_we = 1'b1;
          lh_we   = 1'b1;
          ll_inc  = 1'b1;
        end
      end
      S_PU_WAIT: begin
        // join at the tail, between the old tail and the head
        p_tail_next = prev_q;
        next_we     = 1'b1;
        next_wdata  = p_head;
        prev_we     = 1'b1;
        prev_wdata  = prev_q;
      end
      S_PU_LINK: begin
        next_we    = 1'b1;
        next_waddr = p_tail;
        prev_we    = 1'b1;
        prev_waddr = p_head;
        ll_inc     = 1'b1;
      end
      S_UL_START: begin
        if (l_len == cnt_t'(1)) ll_dec = 1'b1;
      end
      S_UL_WAIT: begin
        next_we    = 1'b1;
        next_waddr = prev_q;
        next_wdata = next_q;
        prev_we    = 1'b1;
        prev_waddr = next_q;
        prev_wdata = prev_q;
        ll_dec     = 1'b1;
        lh_data    = next_q;
        lh_we      = (l_head == a_idx);
      end
      S_TAG: begin
        tag_we     = 1'b1;
        tag_waddr  = a_idx + t_cnt;
        t_cnt_next = t_last ? '0 : t_cnt + idx_t'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_BUILD_INIT;
      ret         <= S_IDLE;
      count       <= cnt_t'(MAX_CHUNKS);
      t_cnt       <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      t_cnt <= t_cnt_next;
      if (cfg_rebuild) count <= cfg_val;
      if ((state == S_DONE) && out_free) rsp_valid_r <= 1'b1;
      else if (rsp.ready) rsp_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top <= top_next;     cur <= cur_next;       ord_r <= ord_r_next;
    a_ord <= a_ord_next; idx_r <= idx_r_next;   base <= base_next;
    a_idx <= a_idx_next; p_head <= p_head_next; p_tail <= p_tail_next;
    res_gr <= res_gr_next; res_st <= res_st_next; op_r <= op_r_next;
    a_free <= a_free_next; off <= off_next;
    if ((state == S_DONE) && out_free) begin
      rsp_status_r  <= res_st;
      rsp_granted_r <= res_gr;
    end
  end

  // list heads and lengths
  always_ff @(posedge clk) begin
    if (list_clr) begin
      for (int i = 0; i < NLIST; i++) begin
        list_head[i] <= '0;
        list_len[i]  <= '0;
      end
    end else begin
      if (lh_we) list_head[lsel] <= lh_data;
      if (ll_inc) list_len[lsel] <= l_len + cnt_t'(1);
      else if (ll_dec) list_len[lsel] <= l_len - cnt_t'(1);
    end
  end

  // tag and link memories
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    tag_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_q <= prev_mem[prev_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_q <= next_mem[next_raddr];
  end

endmodule

>>> rtl/core/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks of the buddy block allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_defines.svh"

module bba_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [1:0]           rsp_status,
  input logic [bba_pkg::IDX_W-1:0] rsp_granted_index
);
  import bba_pkg::*;

  // a held result stays until taken
  `BBA_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
  // a failed request grants no block: its index reads zero
  `BBA_ASSERT_IMP(a_grant_zero, clk, rst, rsp_valid && (rsp_status != ST_OK), rsp_granted_index == '0, "grant on failure")
  // one request in flight
  `BBA_ASSERT_NXT(a_busy_after_take, clk, rst, req_valid && req_ready, !req_ready, "second request taken")
  // reset leaves no stale result
  `BBA_ASSERT_NXT_ALL(a_reset_clear, clk, rst, !rsp_valid, "result after reset")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_granted_index (rsp.granted_index)
);
